[src/slrw_pkg.sv]
// Shared widths, defaults and codes for the sensor log ring window flush unit.
`default_nettype none
package slrw_pkg;
	localparam int unsigned DEF_STORE_DEPTH = 64;
	localparam int unsigned DEF_STAGE_BYTES = 20;
	localparam logic [15:0] INTERVAL_RESET  = 16'd60;
	localparam logic [15:0] DELTA_SAT       = 16'hFFFF;
	localparam int unsigned DIVIDEND_W      = 34;
	localparam int unsigned DIVISOR_W       = 17;
	localparam int unsigned COUNT_W         = 6;
	localparam logic        KIND_ADD        = 1'b0;
	localparam logic        RES_HEADER      = 1'b0;
	localparam logic        RES_RECORD      = 1'b1;
endpackage
`default_nettype wire

[src/sensor_log_ring_window_flush_unit.sv]
// Sensor reading ring store with windowed flush: top level.
// Usage:
//  - Input channel (in_valid/in_ready) carries one item: kind 0 adds a reading,
//    kind 1 flushes. in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready) carries a flush's run: one header item,
//    then the staged records newest first; last marks the final item.
//  - cfg_we/cfg_wdata write measure_interval (reset 60); write only while idle.
// Sequencing:
//  - Add: the bit-serial divider (34 steps) rounds the elapsed time into
//    intervals; the first reading skips the divider.
//  - Flush: one pass summing deltas over the N stored entries, then one pass
//    aging each entry through the multiplier; then each staged record is read
//    and sent, waiting on the receiver.
//  - The entry store has one read port, so each walk step waits on a registered read.
// Reset clears pointer, count and last reading time and sets the interval register
// to 60; entry contents stay undefined until written. A stalled receiver holds the
// output register and the sequencer waits on it; no item is dropped.
`default_nettype none
module sensor_log_ring_window_flush_unit #(
	parameter int unsigned STORE_DEPTH = slrw_pkg::DEF_STORE_DEPTH,
	parameter int unsigned STAGE_BYTES = slrw_pkg::DEF_STAGE_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] now_seconds,
	input  wire logic [31:0] reading,
	input  wire logic [31:0] oldest_age,
	input  wire logic [31:0] youngest_age,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [31:0]      age_seconds,
	output logic [slrw_pkg::COUNT_W-1:0] record_count,
	output logic [15:0]      time_delta,
	output logic [31:0]      value_out,
	output logic             last
);
	import slrw_pkg::*;

	localparam int unsigned PTR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned CNT_W      = $clog2(STORE_DEPTH + 1);
	localparam int unsigned STAGE_LIM  = STAGE_BYTES - 9;
	// records fit while 6*n < limit
	localparam int unsigned STAGE_CAP  = (STAGE_LIM + 5) / 6;
	localparam int unsigned MAX_STAGED = STAGE_BYTES / 6 + 2;
	localparam int unsigned SIDX_W     = $clog2(MAX_STAGED);

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_DIV      = 13'b0000000000010,
		ST_WR       = 13'b0000000000100,
		ST_SUM_RD   = 13'b0000000001000,
		ST_SUM_ACC  = 13'b0000000010000,
		ST_SCALE    = 13'b0000000100000,
		ST_WALK_RD  = 13'b0000001000000,
		ST_WALK_MUL = 13'b0000010000000,
		ST_WALK_CHK = 13'b0000100000000,
		ST_HDR      = 13'b0001000000000,
		ST_REC_RD1  = 13'b0010000000000,
		ST_REC_RD2  = 13'b0100000000000,
		ST_OUT      = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [47:0]         entry_mem [STORE_DEPTH];
	logic [PTR_W-1:0]    stage_mem [MAX_STAGED];

	logic [15:0]         interval_q;
	logic [PTR_W-1:0]    wp_q;
	logic [CNT_W-1:0]    count_q;
	logic [31:0]         last_time_q;

	logic [31:0]         now_q, reading_q, oldest_q, youngest_q;
	logic [15:0]         dl_q;
	logic [PTR_W-1:0]    slot_q;
	logic [CNT_W-1:0]    idx_q;
	logic [31:0]         sum_q, prev_q, rel_q, accum_q;
	logic [COUNT_W-1:0]  n_q, k_q;
	logic [47:0]         rd_q;
	logic [PTR_W-1:0]    rd_addr;
	logic [PTR_W-1:0]    st_rd_q;

	logic                div_start, div_done;
	logic [15:0]         div_quo;
	logic [15:0]         iv_eff;
	logic [31:0]         since;
	logic [31:0]         since_in;
	logic [CNT_W:0]      wp_ext, cnt_ext;
	logic [PTR_W-1:0]    oldest_slot, next_slot;
	logic [31:0]         age;
	logic                take;
	logic [COUNT_W-1:0]  n_new;
	logic [47:0]         scale_prod;
	logic [31:0]         rel_prod;

	assign since   = now_q - last_time_q;
	// divider starts on the accepting edge, so it takes the live input
	assign since_in = now_seconds - last_time_q;
	assign iv_eff  = (interval_q == 16'd0) ? 16'd1 : interval_q;
	assign wp_ext  = {{(CNT_W + 1 - PTR_W){1'b0}}, wp_q};
	assign cnt_ext = {1'b0, count_q};
	always_comb begin
		if (wp_ext >= cnt_ext) begin
			oldest_slot = PTR_W'(wp_ext - cnt_ext);
		end else begin
			oldest_slot = PTR_W'(wp_ext + (CNT_W + 1)'(STORE_DEPTH) - cnt_ext);
		end
	end
	assign next_slot = (slot_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : slot_q + 1'b1;

	assign scale_prod = sum_q * interval_q;
	assign rel_prod   = rd_q[47:32] * interval_q;
	assign age        = prev_q - rel_q;
	assign take       = (n_q < COUNT_W'(STAGE_CAP)) && (age <= oldest_q) &&
	                    (age >= youngest_q);
	assign n_new      = take ? n_q + 1'b1 : n_q;

	assign div_start = (state_q == ST_IDLE) && in_valid && (kind == KIND_ADD) &&
	                   (count_q != '0);

	slrw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({1'b0, since_in, 1'b0} + {18'd0, iv_eff}),
		.divisor  ({iv_eff, 1'b0}),
		.done     (div_done),
		.quotient (div_quo)
	);

	// stage slot read is registered ahead of the entry read that uses it
	assign rd_addr = (state_q == ST_REC_RD1) ? st_rd_q : slot_q;

	// entry store: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_WR) begin
			entry_mem[wp_q] <= {dl_q, reading_q};
		end
		rd_q <= entry_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WALK_CHK) && take) begin
			stage_mem[n_q[SIDX_W-1:0]] <= slot_q;
		end
		st_rd_q <= stage_mem[k_q[SIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			count_q     <= '0;
			last_time_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (kind == KIND_ADD) begin
							state_q <= (count_q == '0) ? ST_WR : ST_DIV;
						end else begin
							state_q <= ST_SUM_RD;
						end
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_WR;
				end
				ST_WR: begin
					wp_q        <= (wp_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
					if (count_q != CNT_W'(STORE_DEPTH)) count_q <= count_q + 1'b1;
					last_time_q <= now_q;
					state_q     <= ST_IDLE;
				end
				ST_SUM_RD: begin
					state_q <= (idx_q == count_q) ? ST_SCALE : ST_SUM_ACC;
				end
				ST_SUM_ACC: state_q <= ST_SUM_RD;
				ST_SCALE:   state_q <= ST_WALK_RD;
				ST_WALK_RD: begin
					state_q <= (idx_q == count_q) ? ST_HDR : ST_WALK_MUL;
				end
				ST_WALK_MUL: state_q <= ST_WALK_CHK;
				ST_WALK_CHK: state_q <= ST_WALK_RD;
				ST_HDR: begin
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_REC_RD1: state_q <= ST_REC_RD2;
				ST_REC_RD2: begin
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= last ? ST_IDLE : ST_REC_RD1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				now_q      <= now_seconds;
				reading_q  <= reading;
				oldest_q   <= oldest_age;
				youngest_q <= youngest_age;
				dl_q       <= '0;
				idx_q      <= '0;
				sum_q      <= '0;
				slot_q     <= oldest_slot;
			end
			ST_DIV: begin
				if (div_done) dl_q <= div_quo;
			end
			ST_SUM_ACC: begin
				sum_q  <= sum_q + {16'd0, rd_q[47:32]};
				slot_q <= next_slot;
				idx_q  <= idx_q + 1'b1;
			end
			ST_SCALE: begin
				prev_q  <= scale_prod[31:0] + since;
				slot_q  <= oldest_slot;
				idx_q   <= '0;
				n_q     <= '0;
				accum_q <= '0;
			end
			ST_WALK_MUL: rel_q <= rel_prod;
			ST_WALK_CHK: begin
				n_q <= n_new;
				// time of entries skipped after staging began counts toward the header
				if ((n_new != '0) && ((age < youngest_q) || (n_new >= COUNT_W'(STAGE_CAP)))) begin
					accum_q <= accum_q + rel_q;
				end
				prev_q <= age;
				slot_q <= next_slot;
				idx_q  <= idx_q + 1'b1;
			end
			ST_HDR: begin
				result_kind  <= RES_HEADER;
				age_seconds  <= since + accum_q;
				record_count <= n_q;
				time_delta   <= '0;
				value_out    <= '0;
				last         <= (n_q == '0);
				k_q          <= n_q - 1'b1;
			end
			ST_REC_RD2: begin
				result_kind  <= RES_RECORD;
				age_seconds  <= '0;
				record_count <= '0;
				time_delta   <= rd_q[47:32];
				value_out    <= rd_q[31:0];
				last         <= (k_q == '0);
				// next stage slot is read while this record waits
				k_q          <= k_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
endmodule
`default_nettype wire

[src/slrw_div.sv]
// Restoring divider, one quotient bit per cycle, saturated 16-bit quotient.
`default_nettype none
module slrw_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [slrw_pkg::DIVIDEND_W-1:0]   dividend,
	input  wire logic [slrw_pkg::DIVISOR_W-1:0]    divisor,
	output logic                                   done,
	output logic [15:0]                            quotient
);
	import slrw_pkg::*;

	localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    trial;
	logic                  qbit;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign qbit    = (shifted >= {1'b0, dvs_q});
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], qbit};
			rem_q <= qbit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[DIVIDEND_W-1:16]) ? DELTA_SAT : quo_q[15:0];
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for the sensor log ring with windowed flush: random and directed items.
`timescale 1ns / 100ps
module tb_top;
	import slrw_pkg::*;

	localparam int unsigned DEPTH       = DEF_STORE_DEPTH;
	// room for records while 6 * staged < STAGE_BYTES - 9
	localparam int unsigned STAGE_ROOM  = DEF_STAGE_BYTES - 9;
	localparam int unsigned STAGE_MAX   = DEF_STAGE_BYTES / 6 + 2;
	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam logic        KIND_FLUSH  = ~KIND_ADD;

	typedef struct packed {
		logic        rkind;
		logic [31:0] age;
		logic [5:0]  count;
		logic [15:0] delta;
		logic [31:0] value;
		logic        last;
	} log_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [31:0] now_seconds;
	logic [31:0] reading;
	logic [31:0] oldest_age;
	logic [31:0] youngest_age;
	logic        out_valid;
	logic        out_ready;
	logic        result_kind;
	logic [31:0] age_seconds;
	logic [COUNT_W-1:0] record_count;
	logic [15:0] time_delta;
	logic [31:0] value_out;
	logic        last;

	sensor_log_ring_window_flush_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .now_seconds(now_seconds), .reading(reading),
		.oldest_age(oldest_age), .youngest_age(youngest_age),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .age_seconds(age_seconds),
		.record_count(record_count), .time_delta(time_delta),
		.value_out(value_out), .last(last)
	);

	// shadow of the log state
	logic [15:0] log_delta [DEPTH];
	logic [31:0] log_value [DEPTH];
	int unsigned log_wp;
	int unsigned log_fill;
	logic [31:0] log_last_time;
	logic [15:0] log_interval;

	log_item_t   flush_run_q [$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned recv_hold;
	logic [31:0] wall_clock;   // running time used to pick now_seconds

	// Clock, run limit
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL sensor_log_ring_window_flush_unit");
			$finish;
		end
	end

	// Work out what one accepted item does to the log and what it emits.
	function automatic void log_apply(logic k, logic [31:0] now, logic [31:0] rd,
			logic [31:0] old_lim, logic [31:0] yng_lim);
		logic [31:0] since, sum, prev, rel, age, accum;
		logic [63:0] iv, q;
		logic [15:0] dl;
		int unsigned slot, n, used, i;
		int unsigned staged [STAGE_MAX];
		log_item_t   it;
		since = now - log_last_time;
		if (k == KIND_ADD) begin
			dl = 16'd0;
			if (log_fill > 0) begin
				iv = (log_interval == 16'd0) ? 64'd1 : 64'(log_interval);
				q  = (64'(since) * 2 + iv) / (2 * iv);
				dl = (q > 64'hFFFF) ? DELTA_SAT : q[15:0];
			end
			log_last_time     = now;
			log_delta[log_wp] = dl;
			log_value[log_wp] = rd;
			log_wp            = (log_wp + 1) % DEPTH;
			if (log_fill < DEPTH) log_fill++;
			return;
		end
		// first pass: total delta over the stored span
		slot = (log_wp + DEPTH - log_fill) % DEPTH;
		sum  = '0;
		for (i = 0; i < log_fill; i++) begin
			sum += 32'(log_delta[(slot + i) % DEPTH]);
		end
		prev  = sum * 32'(log_interval) + since;
		n     = 0;
		used  = 0;
		accum = '0;
		// second pass: oldest to newest, age shrinks by each entry's own span
		for (i = 0; i < log_fill; i++) begin
			rel = 32'(log_delta[slot]) * 32'(log_interval);
			age = prev - rel;
			if (used < STAGE_ROOM && age <= old_lim && age >= yng_lim && n < STAGE_MAX) begin
				staged[n] = slot;
				n++;
				used += 6;
			end
			if (n > 0 && (age < yng_lim || used >= STAGE_ROOM)) accum += rel;
			prev = age;
			slot = (slot + 1) % DEPTH;
		end
		it = '{rkind: RES_HEADER, age: since + accum, count: 6'(n),
			delta: '0, value: '0, last: (n == 0)};
		flush_run_q.push_back(it);
		while (n > 0) begin
			n--;
			it = '{rkind: RES_RECORD, age: '0, count: '0, delta: log_delta[staged[n]],
				value: log_value[staged[n]], last: (n == 0)};
			flush_run_q.push_back(it);
		end
	endfunction

	// Send one item; waits out the sender's random idle time first.
	task automatic send_op(logic k, logic [31:0] now, logic [31:0] rd,
			logic [31:0] old_lim, logic [31:0] yng_lim);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind         = k;
		now_seconds  = now;
		reading      = rd;
		oldest_age   = old_lim;
		youngest_age = yng_lim;
		in_valid     = 1'b1;
		do @(posedge clk); while (!in_ready);
		log_apply(k, now, rd, old_lim, yng_lim);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Let every expected item drain, then allow an add's latency to pass.
	task automatic wait_idle();
		go_quiet();
		while (flush_run_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_interval(logic [15:0] v);
		wait_idle();
		@(negedge clk);
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
		log_interval = v;
	endtask

	task automatic add_reading(logic [31:0] step);
		wall_clock += step;
		send_op(KIND_ADD, wall_clock, $urandom(), $urandom(), $urandom());
	endtask

	// Flush with a window that mostly lands on stored ages.
	task automatic flush_window();
		logic [31:0] span, lo, hi;
		span = 32'(log_interval) * 32'($urandom_range(1, 300));
		case ($urandom_range(0, 5))
			0: begin lo = '0; hi = '1; end
			1: begin lo = '0; hi = $urandom_range(0, 1) ? span : $urandom(); end
			2: begin lo = $urandom_range(0, 2000); hi = '1; end
			3: begin lo = $urandom_range(0, 2000); hi = lo + span; end
			4: begin hi = $urandom_range(0, 2000); lo = hi + 1; end
			default: begin lo = $urandom(); hi = $urandom(); end
		endcase
		wall_clock += $urandom_range(0, 300);
		send_op(KIND_FLUSH, wall_clock, $urandom(), hi, lo);
	endtask

	task automatic run_mix(int unsigned n_items);
		for (int unsigned i = 0; i < n_items; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: flush_window();
				5: add_reading($urandom());          // big jump or clock going back
				6: add_reading('0);
				default: add_reading($urandom_range(0, 3 * log_interval + 10));
			endcase
		end
	endtask

	// Output side: check each item that is taken.
	always @(posedge clk) begin
		log_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (flush_run_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: kind %0d age %0d count %0d delta %0d value %h",
						result_kind, age_seconds, record_count, time_delta, value_out);
			end else begin
				want = flush_run_q.pop_front();
				if (result_kind !== want.rkind || age_seconds !== want.age ||
						record_count !== want.count || time_delta !== want.delta ||
						value_out !== want.value || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp kind %0d age %0d count %0d delta %0d ",
							"value %h last %0d / got %0d %0d %0d %0d %h %0d"},
							want.rkind, want.age, want.count, want.delta, want.value,
							want.last, result_kind, age_seconds, record_count,
							time_delta, value_out, last);
				end
			end
		end
	end

	// Receiver stalls; a long hold counts down on its own.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic test_directed();
		// empty store: header alone
		send_op(KIND_FLUSH, 32'd100, '0, '1, '0);
		// first reading gets delta 0, then extremes of value and time
		wall_clock = '0;
		send_op(KIND_ADD, 32'd0, 32'h0000_0000, '0, '0);
		send_op(KIND_ADD, 32'd60, 32'hFFFF_FFFF, '0, '0);
		send_op(KIND_ADD, 32'd89, 32'hA5A5_5A5A, '1, '1);
		send_op(KIND_ADD, 32'd90, 32'h5A5A_A5A5, '0, '0);
		send_op(KIND_ADD, 32'hFFFF_FFFF, 32'h1234_5678, '0, '0);
		// clock going backwards: the elapsed time wraps modulo 2^32
		send_op(KIND_ADD, 32'd10, 32'h8000_0001, '0, '0);
		send_op(KIND_ADD, 32'd10, 32'h7FFF_FFFE, '0, '0);
		// whole window, empty window, inverted window, narrow window
		send_op(KIND_FLUSH, 32'd500, '0, '1, '0);
		send_op(KIND_FLUSH, 32'd500, '0, '0, '0);
		send_op(KIND_FLUSH, 32'd500, '0, 32'd10, 32'd20);
		send_op(KIND_FLUSH, 32'hFFFF_FFFF, '1, 32'd1000, 32'd400);
		send_op(KIND_FLUSH, 32'd0, '1, '1, 32'hFFFF_FFF0);
		wall_clock = 32'd500;
	endtask

	task automatic test_phase(int unsigned idle_pct, int unsigned stall_pct,
			int unsigned n_items);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		run_mix(n_items);
	endtask

	// Receiver holds off while flushes pile up behind the output register.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		recv_hold = 3000;
		for (int unsigned i = 0; i < 12; i++) begin
			add_reading($urandom_range(0, 200));
			flush_window();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = KIND_ADD;
		now_seconds = '0;
		reading = '0;
		oldest_age = '0;
		youngest_age = '0;
		cycles = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 0;
		wall_clock = '0;
		log_wp = 0;
		log_fill = 0;
		log_last_time = '0;
		log_interval = INTERVAL_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_phase(0, 0, 90);
		set_interval(16'd1);
		test_phase(59, 0, 70);
		set_interval(16'hFFFF);
		test_phase(0, 59, 70);
		set_interval(16'(($urandom_range(2, 900))));
		test_phase(19, 19, 70);
		set_interval(16'd60);
		test_phase(0, 0, 60);
		test_backpressure();

		wait_idle();
		if (mismatches == 0) begin
			$display("PASS sensor_log_ring_window_flush_unit");
		end else begin
			$display("FAIL sensor_log_ring_window_flush_unit");
		end
		$finish;
	end
endmodule
